// File: hw/rtl/tpgs_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the goal steering block.
package tpgs_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN = 24;
  localparam int DIV_BITS = 56;
  localparam int RECIP_STEPS = 4;
  localparam int CNT_W = 6;
  localparam int IN_W = 64;
  localparam int OUT_W = 40;
  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam logic [19:0] MICRO_SCALE = 20'd1000000;
  // ceil(2^64 / 15625): for n below 2^56, floor(n / 10^6) is
  // (floor(n / 64) * RECIP_1E6) >> 64, exactly.
  localparam logic [51:0] RECIP_1E6 = 52'd1180591620717412;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_CRUISE      = 3'd3,
    REG_POS_TOL     = 3'd4,
    REG_ANGLE_TOL   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic arm;
    logic cordic_step;
    logic decide;
    logic mul1;
    logic integ;
    logic mul2;
    logic load_i;
    logic recip_step;
    logic load_d;
    logic div_step;
    logic sum;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic recip_last;
    logic div_last;
    logic run_pid;
  } stat_t;

  // atan(2^-i) in 2^32 units per turn.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10680862;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/three_phase_goal_pid_steering_top.sv
// Top level of the three-phase go-to-goal PID steering controller.
//
// Input stream (s_*): one transfer per item. s_tuser is the item kind: 1 arms
// the controller for a new goal, 0 is a control tick. s_tdata carries the
// goal x and y in millimetres, the goal yaw in binary angle units and the
// time since the previous tick in microseconds.
// Output stream (m_*): exactly one result transfer per input item, in order.
// Items are processed one at a time by a sequencer driving a shared datapath.
// A new-goal result passes through the goal and output states. A control
// tick runs an iterative CORDIC bearing and the phase decision; with a PID
// update, the time taken is set mostly by the 56-step bit-serial division
// of the derivative term by the tick time (the integral term is divided by
// 10^6 with a reciprocal multiplication built from 26 x 26 partial
// products). The input is ready again in the cycle after a result is
// loaded into the output register, as the sequencer then returns to idle.
// A result sits in the output register until taken; the next item is
// accepted meanwhile, and its result waits in the datapath, with the input
// held not ready, if the receiver still stalls. Configuration writes take
// effect at once and belong in idle periods. Synchronous reset restores the
// default gains and tolerances, returns the controller to idle and clears
// the PID state.
module three_phase_goal_pid_steering_top #(
  parameter int CORDIC_STEPS = tpgs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // fields from bit 0: target_x[15:0], target_y[15:0], target_yaw[15:0], elapsed_us[15:0]
  input  logic [tpgs_pkg::IN_W-1:0]       s_tdata,
  // fields from bit 0: func
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fields from bit 0: forward_speed[11:0], turn_rate[23:0], phase_now[1:0], goal_done, pad
  output logic [tpgs_pkg::OUT_W-1:0]      m_tdata,
  input  logic                            cfg_we,
  input  logic [tpgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpgs_pkg::CFG_W-1:0]      cfg_data
);
  import tpgs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tpgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpgs_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

// File: hw/rtl/tpgs_ctrl.sv
// Sequencer state machine of the goal steering block.
module tpgs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           s_tuser,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  tpgs_pkg::stat_t stat,
  output tpgs_pkg::cmd_t  cmd
);
  import tpgs_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_GOAL   = 13'b0000000000010,
    S_CORDIC = 13'b0000000000100,
    S_DECIDE = 13'b0000000001000,
    S_MUL1   = 13'b0000000010000,
    S_INTEG  = 13'b0000000100000,
    S_MUL2   = 13'b0000001000000,
    S_LOADI  = 13'b0000010000000,
    S_RECIP  = 13'b0000100000000,
    S_LOADD  = 13'b0001000000000,
    S_DIVD   = 13'b0010000000000,
    S_SUM    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = s_tuser ? S_GOAL : S_CORDIC;
        end
      end
      S_GOAL: begin
        cmd.arm = 1'b1;
        state_next = S_OUT;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (stat.cordic_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.run_pid ? S_MUL1 : S_OUT;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_LOADI;
      end
      S_LOADI: begin
        cmd.load_i = 1'b1;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.recip_step = 1'b1;
        if (stat.recip_last) state_next = S_LOADD;
      end
      S_LOADD: begin
        cmd.load_d = 1'b1;
        state_next = S_DIVD;
      end
      S_DIVD: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/tpgs_datapath.sv
// Datapath of the goal steering block: CORDIC, phase logic, PID arithmetic, divider.
module tpgs_datapath #(
  parameter int CORDIC_STEPS = tpgs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tpgs_pkg::cmd_t                  cmd,
  output tpgs_pkg::stat_t                 stat,
  input  logic [tpgs_pkg::IN_W-1:0]       s_tdata,
  input  logic                            cfg_we,
  input  logic [tpgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpgs_pkg::CFG_W-1:0]      cfg_data,
  output logic [tpgs_pkg::OUT_W-1:0]      m_tdata
);
  import tpgs_pkg::*;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  // Configuration registers.
  logic [23:0] prop_gain, integ_gain, deriv_gain;
  logic [11:0] cruise_speed, pos_tol;
  logic [14:0] ang_tol;

  // Controller state.
  logic [1:0]          phase;
  logic                entered;
  logic signed [15:0]  prev_error;
  logic signed [47:0]  integral;
  logic [CNT_W-1:0]    cnt;

  // Item and work registers.
  logic signed [15:0]  tx, ty, tyaw;
  logic [15:0]         dt;
  logic signed [34:0]  cx, cy;
  logic [31:0]         cz;
  logic signed [15:0]  e_reg;
  logic signed [16:0]  d_reg;
  logic signed [32:0]  prod_edt;
  logic [39:0]         prod_p, prod_d;
  logic [55:0]         prod_i;
  logic [59:0]         prod_d2;
  logic [23:0]         p_mag;
  logic [55:0]         i_mag;
  logic                i_neg;
  logic [103:0]        acc;
  logic [55:0]         dq;
  logic [19:0]         drem, dden;
  logic [11:0]         res_speed;
  logic [23:0]         res_rate;
  logic [1:0]          res_phase;
  logic                res_done;

  // Capture-time CORDIC set-up: fold the left half plane onto the right.
  logic signed [15:0]  x_in, y_in;
  logic [15:0]         dt_in;
  logic signed [16:0]  xs, ys;
  assign x_in  = s_tdata[15:0];
  assign y_in  = s_tdata[31:16];
  assign dt_in = s_tdata[63:48];
  assign xs = x_in[15] ? -{x_in[15], x_in} : {x_in[15], x_in};
  assign ys = x_in[15] ? -{y_in[15], y_in} : {y_in[15], y_in};

  logic [4:0]          sh;
  logic signed [34:0]  cx_sh, cy_sh;
  assign sh = cnt[4:0];
  assign cx_sh = cx >>> sh;
  assign cy_sh = cy >>> sh;

  // Bearing in binary angle units, rounded half up.
  logic [31:0]         z_round;
  logic signed [15:0]  bear;
  assign z_round = cz + 32'h0000_8000;
  assign bear = (tx == 16'sd0 && ty == 16'sd0) ? 16'sd0 : $signed(z_round[31:16]);

  // Phase resolution for one tick.
  logic bear_big, yaw_big, near;
  logic [1:0] fp;
  logic run, clr, spd_on, done, trans, ent_eff;
  logic signed [15:0] e_sel, prev_use;
  assign bear_big = mag16(bear) > {1'b0, ang_tol};
  assign yaw_big  = mag16(tyaw) > {1'b0, ang_tol};
  assign near = (mag16(tx) < {4'b0, pos_tol}) && (mag16(ty) < {4'b0, pos_tol});

  always_comb begin
    fp = phase;
    run = 1'b0;
    clr = 1'b0;
    spd_on = 1'b0;
    done = 1'b0;
    e_sel = bear;
    unique case (phase)
      2'd1: begin
        if (bear_big) begin
          run = 1'b1;
        end else begin
          clr = 1'b1;
          if (!near) begin
            fp = 2'd2; run = 1'b1; spd_on = 1'b1;
          end else if (yaw_big) begin
            fp = 2'd3; run = 1'b1; e_sel = tyaw;
          end else begin
            fp = 2'd0; done = 1'b1;
          end
        end
      end
      2'd2: begin
        if (!near) begin
          run = 1'b1; spd_on = 1'b1;
        end else if (yaw_big) begin
          fp = 2'd3; run = 1'b1; e_sel = tyaw;
        end else begin
          fp = 2'd0; done = 1'b1;
        end
      end
      2'd3: begin
        e_sel = tyaw;
        if (yaw_big) run = 1'b1;
        else begin
          fp = 2'd0; done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign trans = (fp != phase);
  assign ent_eff = trans ? 1'b0 : entered;
  assign prev_use = ent_eff ? prev_error : e_sel;

  assign stat.run_pid = run;
  assign stat.cordic_last = (cnt == CNT_W'(CORDIC_STEPS - 1));
  assign stat.recip_last = (cnt == CNT_W'(RECIP_STEPS - 1));
  assign stat.div_last = (cnt == CNT_W'(DIV_BITS - 1));

  // Integral update with saturation.
  logic signed [48:0] isum;
  logic signed [47:0] isat;
  logic [47:0]        i_abs;
  assign isum = {integral[47], integral} + {{16{prod_edt[32]}}, prod_edt};
  always_comb begin
    if (isum[48] != isum[47]) isat = isum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    else isat = isum[47:0];
  end
  assign i_abs = integral[47] ? 48'(-integral) : integral;

  logic [15:0] d_mag;
  assign d_mag = d_reg[16] ? 16'(-d_reg) : d_reg[15:0];

  // Integral term divided by 10^6: the product is shifted down by 6 and multiplied by
  // the reciprocal of 15625, one 26 x 26 partial product per cycle.
  logic [51:0]  n_rec;
  logic [25:0]  rec_a, rec_b;
  logic [51:0]  rec_pp;
  logic [103:0] rec_add;
  assign n_rec = {2'b0, prod_i[55:6]};
  assign rec_a = cnt[1] ? n_rec[51:26] : n_rec[25:0];
  assign rec_b = cnt[0] ? RECIP_1E6[51:26] : RECIP_1E6[25:0];
  assign rec_pp = 52'(rec_a) * 52'(rec_b);
  always_comb begin
    unique case (cnt[1:0])
      2'd0:       rec_add = {52'b0, rec_pp};
      2'd1, 2'd2: rec_add = {26'b0, rec_pp, 26'b0};
      2'd3:       rec_add = {rec_pp, 52'b0};
    endcase
  end

  // Restoring divider step.
  logic [20:0] dt_try;
  logic        dge;
  assign dt_try = {drem, dq[55]};
  assign dge = dt_try >= {1'b0, dden};

  // Final sum and saturation.
  logic signed [57:0] p_s, i_s, d_s, tot;
  logic [23:0] rate_sat;
  assign p_s = e_reg[15] ? -$signed({34'b0, p_mag}) : $signed({34'b0, p_mag});
  assign i_s = i_neg ? -$signed({2'b0, i_mag}) : $signed({2'b0, i_mag});
  assign d_s = d_reg[16] ? -$signed({2'b0, dq}) : $signed({2'b0, dq});
  assign tot = p_s + i_s + d_s;
  always_comb begin
    if (tot > 58'sd8388607) rate_sat = 24'h7F_FFFF;
    else if (tot < -58'sd8388608) rate_sat = 24'h80_0000;
    else rate_sat = tot[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= 24'd131072;
      integ_gain <= 24'd655;
      deriv_gain <= 24'd66;
      cruise_speed <= 12'd300;
      pos_tol <= 12'd50;
      ang_tol <= 15'd1820;
      phase <= 2'd0;
      entered <= 1'b0;
      prev_error <= '0;
      integral <= '0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:  prop_gain <= cfg_data;
          REG_INTEG_GAIN: integ_gain <= cfg_data;
          REG_DERIV_GAIN: deriv_gain <= cfg_data;
          REG_CRUISE:     cruise_speed <= cfg_data[11:0];
          REG_POS_TOL:    pos_tol <= cfg_data[11:0];
          REG_ANGLE_TOL:  ang_tol <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (cmd.capture || cmd.load_i || cmd.load_d) cnt <= '0;
      else if (cmd.cordic_step || cmd.div_step || cmd.recip_step) cnt <= cnt + 1'b1;
      if (cmd.arm) begin
        phase <= 2'd1;
        entered <= 1'b0;
        integral <= '0;
      end
      if (cmd.decide) begin
        phase <= fp;
        entered <= run ? 1'b1 : ent_eff;
        if (run) prev_error <= e_sel;
        if (clr) integral <= '0;
      end
      if (cmd.integ) integral <= isat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tx <= x_in;
      ty <= y_in;
      tyaw <= s_tdata[47:32];
      dt <= (dt_in == 16'd0) ? 16'd1 : dt_in;
      cx <= {{2{xs[16]}}, xs, 16'h0000};
      cy <= {{2{ys[16]}}, ys, 16'h0000};
      cz <= x_in[15] ? 32'h8000_0000 : 32'h0000_0000;
    end
    if (cmd.cordic_step) begin
      if (!cy[34]) begin
        cx <= cx + cy_sh;
        cy <= cy - cx_sh;
        cz <= cz + atan_entry(sh);
      end else begin
        cx <= cx - cy_sh;
        cy <= cy + cx_sh;
        cz <= cz - atan_entry(sh);
      end
    end
    if (cmd.arm) begin
      res_speed <= '0;
      res_rate <= '0;
      res_phase <= 2'd1;
      res_done <= 1'b0;
    end
    if (cmd.decide) begin
      e_reg <= e_sel;
      d_reg <= {e_sel[15], e_sel} - {prev_use[15], prev_use};
      res_phase <= fp;
      res_done <= done;
      res_speed <= spd_on ? cruise_speed : 12'd0;
      res_rate <= '0;
    end
    if (cmd.mul1) begin
      prod_edt <= $signed({{17{e_reg[15]}}, e_reg}) * $signed({17'b0, dt});
      prod_p <= 40'(prop_gain) * 40'(mag16(e_reg));
      prod_d <= 40'(deriv_gain) * 40'(d_mag);
    end
    if (cmd.integ) p_mag <= prod_p[39:16];
    if (cmd.mul2) begin
      prod_i <= 56'(i_abs[47:16]) * 56'(integ_gain);
      i_neg <= integral[47];
      prod_d2 <= 60'(prod_d) * 60'(MICRO_SCALE);
    end
    if (cmd.load_i) acc <= '0;
    if (cmd.recip_step) acc <= acc + rec_add;
    if (cmd.load_d) begin
      i_mag <= {16'b0, acc[103:64]};
      dq <= {12'b0, prod_d2[59:16]};
      drem <= '0;
      dden <= {4'b0, dt};
    end
    if (cmd.div_step) begin
      drem <= dge ? 20'(dt_try - {1'b0, dden}) : dt_try[19:0];
      dq <= {dq[54:0], dge};
    end
    if (cmd.sum) res_rate <= rate_sat;
    if (cmd.load_out) m_tdata <= {1'b0, res_done, res_phase, res_rate, res_speed};
  end

endmodule

// File: hw/rtl/tpgs_checker.sv
// Port-level checker for the goal steering block, with its bind statement.
module tpgs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [tpgs_pkg::OUT_W-1:0] m_tdata
);
  import tpgs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[38] |->
      m_tdata[37:36] == 2'd0 && m_tdata[11:0] == 12'd0 && m_tdata[35:12] == 24'd0)
    else $error("goal done without stop command");

  a_speed_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11:0] != 12'd0 |-> m_tdata[37:36] == 2'd2)
    else $error("forward speed outside drive phase");

endmodule

bind three_phase_goal_pid_steering_top tpgs_checker u_chk (.*);
